// ----- sv/nand_flash_page_array_model_assert.svh -----
// Assertion macros for the NAND flash page array model checker.
// No dependencies; the including module provides i_clk and i_rst_n.
`ifndef NAND_FLASH_PAGE_ARRAY_MODEL_ASSERT_SVH
`define NAND_FLASH_PAGE_ARRAY_MODEL_ASSERT_SVH

// same-cycle implication
`define NFPA_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("nfpa: same-cycle check failed");

// next-cycle implication
`define NFPA_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("nfpa: next-cycle check failed");

`endif

// ----- sv/nfpa_pkg.sv -----
// Shared types and constants for the NAND flash page array model.
// No dependencies.
package nfpa_pkg;

    localparam int REQ_W      = 2;
    localparam int BANK_W     = 2;
    localparam int BLOCK_W    = 6;
    localparam int PAGE_W     = 5;
    localparam int DATA_W     = 32;
    localparam int SPARE_W    = 8;
    localparam int STATUS_W   = 3;
    localparam int FILL_W     = 6;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;
    localparam int NBANK_W    = 3;
    localparam int NBLOCK_W   = 7;
    localparam int NPAGE_W    = 6;

    localparam logic [CFG_IDX_W-1:0] CFG_NUM_BANKS       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCKS_PER_BANK = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PAGES_PER_BLOCK = 2'd2;

    typedef enum logic [REQ_W-1:0] {
        REQ_READ,
        REQ_WRITE,
        REQ_ERASE,
        REQ_DUMP
    } t_req;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK,
        ST_BAD_BANK,
        ST_BAD_BLOCK,
        ST_BAD_PAGE,
        ST_WRITTEN,
        ST_NOT_SEQ,
        ST_EMPTY,
        ST_FREE
    } t_status;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_CHECK,
        S_READ,
        S_DUMP
    } t_state;

endpackage

// ----- sv/nfpa_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module nfpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic                                   i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- sv/nand_flash_page_array_model.sv -----
// Top level of the NAND flash page array model: sequencer, fill-count RAM, page RAM.
// Depends on nfpa_pkg and nfpa_ram.
//
// channel   direction  handshake            payload
// request   in         start / busy         i_req_type .. i_write_spare
// result    out        o_valid (one cycle)  o_status .. o_last
// config    in         i_cfg_we             i_cfg_idx, i_cfg_wdata
//
// Write, erase, every failure: answered from the check state; read: via the read state.
// Dump: a count header, then one page word per cycle from the page RAM port.
// After reset a clearing pass zeroes the fill counts, one entry per bank and block,
// with busy high. Results cannot be stalled.
module nand_flash_page_array_model #(
    parameter int MAX_BANKS  = 4,
    parameter int MAX_BLOCKS = 64,
    parameter int MAX_PAGES  = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [nfpa_pkg::REQ_W-1:0]        i_req_type,
    input  logic [nfpa_pkg::BANK_W-1:0]       i_bank_index,
    input  logic [nfpa_pkg::BLOCK_W-1:0]      i_block_index,
    input  logic [nfpa_pkg::PAGE_W-1:0]       i_page_index,
    input  logic [nfpa_pkg::DATA_W-1:0]       i_write_data,
    input  logic [nfpa_pkg::SPARE_W-1:0]      i_write_spare,
    input  logic                              i_cfg_we,
    input  logic [nfpa_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [nfpa_pkg::CFG_DATA_W-1:0]   i_cfg_wdata,
    output logic                              o_valid,
    output logic [nfpa_pkg::STATUS_W-1:0]     o_status,
    output logic [nfpa_pkg::DATA_W-1:0]       o_read_data,
    output logic [nfpa_pkg::SPARE_W-1:0]      o_read_spare,
    output logic [nfpa_pkg::PAGE_W-1:0]       o_result_page,
    output logic [nfpa_pkg::FILL_W-1:0]       o_written_count,
    output logic                              o_is_header,
    output logic                              o_last
);
    import nfpa_pkg::*;

    localparam int NBLK   = MAX_BANKS * MAX_BLOCKS;
    localparam int NPG    = NBLK * MAX_PAGES;
    localparam int BLK_AW = (NBLK > 1) ? $clog2(NBLK) : 1;
    localparam int PG_AW  = (NPG > 1) ? $clog2(NPG) : 1;
    localparam int PG_DW  = DATA_W + SPARE_W;
    localparam logic [FILL_W-1:0]  PAGES_CAP = FILL_W'(MAX_PAGES);
    localparam logic [BLK_AW-1:0]  CLR_LAST  = BLK_AW'(NBLK - 1);

    t_state                r_state, n_state;
    logic [NBANK_W-1:0]    r_num_banks, n_num_banks;
    logic [NBLOCK_W-1:0]   r_blocks, n_blocks;
    logic [NPAGE_W-1:0]    r_pages, n_pages;
    logic [BLK_AW-1:0]     r_clr, n_clr;
    t_req                  r_op, n_op;
    logic [BANK_W-1:0]     r_bank, n_bank;
    logic [BLOCK_W-1:0]    r_block, n_block;
    logic [PAGE_W-1:0]     r_page, n_page;
    logic [DATA_W-1:0]     r_wdata, n_wdata;
    logic [SPARE_W-1:0]    r_wspare, n_wspare;
    logic [BLK_AW-1:0]     r_bidx, n_bidx;
    logic [FILL_W-1:0]     r_eff, n_eff;
    logic [FILL_W-1:0]     r_cnt, n_cnt;
    logic                  r_valid, n_valid;
    t_status               r_status, n_status;
    logic [DATA_W-1:0]     r_rdata, n_rdata;
    logic [SPARE_W-1:0]    r_rspare, n_rspare;
    logic [PAGE_W-1:0]     r_rpage, n_rpage;
    logic [FILL_W-1:0]     r_wcount, n_wcount;
    logic                  r_hdr, n_hdr;
    logic                  r_last, n_last;

    logic                  fill_we, fill_re;
    logic [BLK_AW-1:0]     fill_waddr, fill_raddr;
    logic [FILL_W-1:0]     fill_wdata, fill_q;
    logic                  pg_we, pg_re;
    logic [PG_AW-1:0]      pg_addr, pg_base;
    logic [PG_DW-1:0]      pg_q;
    logic [FILL_W-1:0]     rd_page;

    logic                  bank_bad, blk_bad, page_bad, rw_op;
    logic [FILL_W-1:0]     np, eff, page_ext, cnt_inc;

    nfpa_ram #(.WIDTH(FILL_W), .DEPTH(NBLK)) u_fill_ram (
        .i_clk   (i_clk),
        .i_we    (fill_we),
        .i_waddr (fill_waddr),
        .i_wdata (fill_wdata),
        .i_re    (fill_re),
        .i_raddr (fill_raddr),
        .o_rdata (fill_q)
    );

    nfpa_ram #(.WIDTH(PG_DW), .DEPTH(NPG)) u_page_ram (
        .i_clk   (i_clk),
        .i_we    (pg_we),
        .i_waddr (pg_addr),
        .i_wdata ({r_wdata, r_wspare}),
        .i_re    (pg_re),
        .i_raddr (pg_addr),
        .o_rdata (pg_q)
    );

    assign bank_bad = ({1'b0, r_bank} >= r_num_banks) || (32'(r_bank) >= 32'(MAX_BANKS));
    assign blk_bad  = ({1'b0, r_block} >= r_blocks) || (32'(r_block) >= 32'(MAX_BLOCKS));
    assign np       = (r_pages < PAGES_CAP) ? r_pages : PAGES_CAP;
    assign page_ext = {1'b0, r_page};
    assign page_bad = (page_ext >= np);
    assign eff      = (fill_q < np) ? fill_q : np;
    assign rw_op    = (r_op == REQ_READ) || (r_op == REQ_WRITE);
    assign cnt_inc  = r_cnt + FILL_W'(1);
    assign pg_base  = PG_AW'(32'(r_bidx) * 32'(MAX_PAGES));
    assign pg_addr  = pg_base + PG_AW'(rd_page);

    always_comb begin
        n_state     = r_state;
        n_num_banks = r_num_banks;
        n_blocks    = r_blocks;
        n_pages     = r_pages;
        n_clr       = r_clr;
        n_op        = r_op;
        n_bank      = r_bank;
        n_block     = r_block;
        n_page      = r_page;
        n_wdata     = r_wdata;
        n_wspare    = r_wspare;
        n_bidx      = r_bidx;
        n_eff       = r_eff;
        n_cnt       = r_cnt;
        n_valid     = 1'b0;
        n_status    = r_status;
        n_rdata     = r_rdata;
        n_rspare    = r_rspare;
        n_rpage     = r_rpage;
        n_wcount    = r_wcount;
        n_hdr       = r_hdr;
        n_last      = r_last;
        fill_we     = 1'b0;
        fill_waddr  = r_bidx;
        fill_wdata  = '0;
        fill_re     = 1'b0;
        fill_raddr  = r_bidx;
        pg_we       = 1'b0;
        pg_re       = 1'b0;
        rd_page     = page_ext;

        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_NUM_BANKS:       n_num_banks = i_cfg_wdata[NBANK_W-1:0];
                CFG_BLOCKS_PER_BANK: n_blocks    = i_cfg_wdata[NBLOCK_W-1:0];
                CFG_PAGES_PER_BLOCK: n_pages     = i_cfg_wdata[NPAGE_W-1:0];
                default: ;
            endcase
        end

        unique case (r_state)
            S_CLEAR: begin
                fill_we    = 1'b1;
                fill_waddr = r_clr;
                if (r_clr == CLR_LAST) begin
                    n_state = S_IDLE;
                end else begin
                    n_clr = r_clr + BLK_AW'(1);
                end
            end
            S_IDLE: begin
                if (start) begin
                    n_op       = t_req'(i_req_type);
                    n_bank     = i_bank_index;
                    n_block    = i_block_index;
                    n_page     = i_page_index;
                    n_wdata    = i_write_data;
                    n_wspare   = i_write_spare;
                    n_bidx     = BLK_AW'(32'(i_bank_index) * 32'(MAX_BLOCKS)
                                         + 32'(i_block_index));
                    fill_re    = 1'b1;
                    fill_raddr = n_bidx;
                    n_state    = S_CHECK;
                end
            end
            S_CHECK: begin
                n_state  = S_IDLE;
                n_valid  = 1'b1;
                n_status = ST_OK;
                n_rdata  = '0;
                n_rspare = '0;
                n_rpage  = rw_op ? r_page : '0;
                n_wcount = '0;
                n_hdr    = 1'b0;
                n_last   = 1'b1;
                priority if (bank_bad) begin
                    n_status = ST_BAD_BANK;
                end else if (blk_bad) begin
                    n_status = ST_BAD_BLOCK;
                end else if (rw_op && page_bad) begin
                    n_status = ST_BAD_PAGE;
                end else begin
                    unique case (r_op)
                        REQ_READ: begin
                            if (page_ext >= eff) begin
                                n_status = ST_EMPTY;
                            end else begin
                                n_valid = 1'b0;
                                pg_re   = 1'b1;
                                n_state = S_READ;
                            end
                        end
                        REQ_WRITE: begin
                            priority if (page_ext < fill_q) begin
                                n_status = ST_WRITTEN;
                            end else if (page_ext > fill_q) begin
                                n_status = ST_NOT_SEQ;
                            end else begin
                                pg_we      = 1'b1;
                                fill_we    = 1'b1;
                                fill_wdata = fill_q + FILL_W'(1);
                            end
                        end
                        REQ_ERASE: begin
                            if (eff == '0) begin
                                n_status = ST_FREE;
                            end else begin
                                fill_we = 1'b1;
                            end
                        end
                        REQ_DUMP: begin
                            n_hdr    = 1'b1;
                            n_wcount = eff;
                            n_last   = (eff == '0);
                            n_eff    = eff;
                            n_cnt    = '0;
                            if (eff != '0) begin
                                pg_re   = 1'b1;
                                rd_page = '0;
                                n_state = S_DUMP;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_READ: begin
                n_valid  = 1'b1;
                n_status = ST_OK;
                n_rdata  = pg_q[PG_DW-1:SPARE_W];
                n_rspare = pg_q[SPARE_W-1:0];
                n_rpage  = r_page;
                n_wcount = '0;
                n_hdr    = 1'b0;
                n_last   = 1'b1;
                n_state  = S_IDLE;
            end
            S_DUMP: begin
                n_valid  = 1'b1;
                n_status = ST_OK;
                n_rdata  = pg_q[PG_DW-1:SPARE_W];
                n_rspare = pg_q[SPARE_W-1:0];
                n_rpage  = r_cnt[PAGE_W-1:0];
                n_wcount = '0;
                n_hdr    = 1'b0;
                n_last   = (cnt_inc == r_eff);
                if (cnt_inc == r_eff) begin
                    n_state = S_IDLE;
                end else begin
                    pg_re   = 1'b1;
                    rd_page = cnt_inc;
                    n_cnt   = cnt_inc;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_valid     <= 1'b0;
            r_num_banks <= NBANK_W'(4);
            r_blocks    <= NBLOCK_W'(64);
            r_pages     <= NPAGE_W'(32);
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_valid     <= n_valid;
            r_num_banks <= n_num_banks;
            r_blocks    <= n_blocks;
            r_pages     <= n_pages;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op     <= n_op;
        r_bank   <= n_bank;
        r_block  <= n_block;
        r_page   <= n_page;
        r_wdata  <= n_wdata;
        r_wspare <= n_wspare;
        r_bidx   <= n_bidx;
        r_eff    <= n_eff;
        r_cnt    <= n_cnt;
        r_status <= n_status;
        r_rdata  <= n_rdata;
        r_rspare <= n_rspare;
        r_rpage  <= n_rpage;
        r_wcount <= n_wcount;
        r_hdr    <= n_hdr;
        r_last   <= n_last;
    end

    assign busy            = (r_state != S_IDLE);
    assign o_valid         = r_valid;
    assign o_status        = r_status;
    assign o_read_data     = r_rdata;
    assign o_read_spare    = r_rspare;
    assign o_result_page   = r_rpage;
    assign o_written_count = r_wcount;
    assign o_is_header     = r_hdr;
    assign o_last          = r_last;

endmodule

// ----- sv/nfpa_checker.sv -----
// Port-level checker for the NAND flash page array model, bound to the top level.
// Depends on nfpa_pkg and nand_flash_page_array_model_assert.svh.
`include "nand_flash_page_array_model_assert.svh"

module nfpa_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            start,
    input logic                            busy,
    input logic                            o_valid,
    input logic [nfpa_pkg::STATUS_W-1:0]   o_status,
    input logic                            o_is_header,
    input logic                            o_last
);
    import nfpa_pkg::*;

    // a dump streams its words without gaps
    `NFPA_ASSERT_NXT(a_dump_no_gap, o_valid && !o_last, o_valid)
    `NFPA_ASSERT_IMP(a_busy_mid_dump, o_valid && !o_last, busy)
    `NFPA_ASSERT_NXT(a_busy_after_start, start && !busy, busy)
    `NFPA_ASSERT_IMP(a_error_is_last,
        o_valid && (o_status != ST_OK), o_last && !o_is_header)

endmodule

bind nand_flash_page_array_model nfpa_checker u_nfpa_checker (.*);
